@@ design/dominator_tree_fixpoint_top_macros.svh @@
// Assertion helpers for the dominator tree block.
`ifndef DOMINATOR_TREE_FIXPOINT_TOP_MACROS_SVH
`define DOMINATOR_TREE_FIXPOINT_TOP_MACROS_SVH

// Same-cycle implication.
`define DTF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dtf_pkg.sv @@
`default_nettype none
package dtf_pkg;

    localparam int SLOT_W = 6;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] NODE_SPACE_RST = 7'd64;

    typedef struct packed {
        logic [SLOT_W-1:0] node;
        logic [SLOT_W-1:0] pred;
        logic              has_pred;
        logic              node_done;
        logic              graph_done;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] out_node;
        logic [SLOT_W-1:0] dominator;
        logic              has_dominator;
        logic              gave_up;
        logic              overflow;
        logic              last;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_I0,
        OP_ROOT,
        OP_SWEEP,
        OP_SETTLE,
        OP_NODE,
        OP_EADDR,
        OP_PRED,
        OP_SKIP,
        OP_TAKE,
        OP_MSTART,
        OP_MEET_OK,
        OP_FAIL,
        OP_STEP,
        OP_MOVE_A,
        OP_MOVE_B,
        OP_FIN,
        OP_UPDATE,
        OP_EPICK,
        OP_EOUT,
        OP_EEMPTY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic pc_zero;
        logic i_done;
        logic k_done;
        logic rpo_a_ok;
        logic rpo_b_ok;
        logic dom_a_ok;
        logic dom_b_ok;
        logic pick_ok;
        logic a_eq_b;
        logic a_gt_b;
        logic b_gt_a;
        logic steps_over;
        logic sweep_more;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ design/dtf_dp.sv @@
`default_nettype none
`include "dominator_tree_fixpoint_top_macros.svh"
module dtf_dp #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [dtf_pkg::CFG_W-1:0] i_cfg_data,
    input  wire dtf_pkg::t_in            i_req,
    input  wire dtf_pkg::t_cmd           i_cmd,
    input  wire logic                    i_stall,
    output dtf_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output dtf_pkg::t_out                o_rsp
);
    import dtf_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);

    logic [CFG_W-1:0] r_ns;
    logic             r_open, r_kept, r_ovf;
    logic [NW:0]      r_pc, n_pc;
    logic [EW:0]      r_el, n_el, r_cur, n_cur;
    logic             n_open, n_kept, n_ovf;
    logic [MAX_NODES-1:0] r_rpo_vld, n_rpo_vld, r_dom_vld, n_dom_vld;
    logic [MAX_NODES-1:0] r_gaveup, n_gaveup, r_moved, n_moved;

    logic [NW-1:0] r_rpo_mem [MAX_NODES];
    logic [NW-1:0] r_dom_mem [MAX_NODES];
    logic [NW-1:0] r_order_mem [MAX_NODES];
    logic [EW:0]   r_estart_mem [MAX_NODES];
    logic [EW:0]   r_ecount_mem [MAX_NODES];
    logic [NW-1:0] r_edge_mem [MAX_EDGES];

    logic [NW:0]   r_i, n_i;
    logic [EW-1:0] r_e, n_e;
    logic [EW:0]   r_k, n_k, r_start, n_start, r_cnt, n_cnt;
    logic [NW-1:0] r_bnode, n_bnode, r_pick, n_pick, r_a, n_a, r_b, n_b;
    logic          r_pick_ok, n_pick_ok, r_changed, n_changed;
    logic [7:0]    r_steps, n_steps, r_sweeps, n_sweeps;

    logic [NW-1:0] r_rpo_a, r_rpo_b, r_dom_a, r_dom_b;
    logic          r_rpo_a_ok, r_rpo_b_ok, r_dom_a_ok, r_dom_b_ok;
    logic [NW-1:0] r_order_rd, r_edge_rd;
    logic [EW:0]   r_estart_rd, r_ecount_rd;

    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic [CFG_W-1:0] w_sp;
    logic [7:0]       w_cap;
    logic             w_first, w_node_bad, w_kept, w_edge_try, w_edge_bad, w_edge_ok;
    logic [NW:0]      w_pos;
    logic [EW:0]      w_cnt_new, w_esum;
    logic             w_upd, w_out_free;

    logic             w_ord_we, w_cnt_we, w_rpo_we, w_dom_we, w_edge_we;
    logic [NW-1:0]    w_ord_wa, w_cnt_wa, w_rpo_wa, w_dom_wa, w_dom_wd;
    logic [EW-1:0]    w_edge_wa;

    always_comb begin
        if (r_ns == '0) begin
            w_sp = CFG_W'(1);
        end else if (r_ns > CFG_W'(MAX_NODES)) begin
            w_sp = CFG_W'(MAX_NODES);
        end else begin
            w_sp = r_ns;
        end
    end

    assign w_cap      = {w_sp, 1'b0} + 8'd4;
    assign w_first    = !r_open;
    assign w_node_bad = ({1'b0, i_req.node} >= w_sp) || r_rpo_vld[i_req.node[NW-1:0]]
                        || (r_pc >= (NW+1)'(MAX_NODES));
    assign w_kept     = w_first ? !w_node_bad : r_kept;
    assign w_edge_try = i_req.has_pred && w_kept;
    assign w_edge_bad = ({1'b0, i_req.pred} >= w_sp) || (r_el >= (EW+1)'(MAX_EDGES));
    assign w_edge_ok  = w_edge_try && !w_edge_bad;
    assign w_pos      = w_first ? r_pc : r_pc - (NW+1)'(1);
    assign w_cnt_new  = (w_first ? '0 : r_cur) + (EW+1)'(w_edge_ok);
    assign w_esum     = r_start + r_k;
    assign w_upd      = r_pick_ok && (!r_dom_b_ok || (r_dom_b != r_pick));
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_pc = r_pc; n_el = r_el; n_cur = r_cur; n_open = r_open; n_kept = r_kept;
        n_ovf = r_ovf; n_rpo_vld = r_rpo_vld; n_dom_vld = r_dom_vld;
        n_gaveup = r_gaveup; n_moved = r_moved;
        n_i = r_i; n_e = r_e; n_k = r_k; n_start = r_start; n_cnt = r_cnt;
        n_bnode = r_bnode; n_pick = r_pick; n_pick_ok = r_pick_ok; n_a = r_a; n_b = r_b;
        n_changed = r_changed; n_steps = r_steps; n_sweeps = r_sweeps;
        n_out = r_out;
        n_out_valid = r_out_valid && i_stall;
        w_ord_we = 1'b0; w_cnt_we = 1'b0; w_rpo_we = 1'b0; w_dom_we = 1'b0; w_edge_we = 1'b0;
        w_ord_wa = r_pc[NW-1:0]; w_cnt_wa = w_pos[NW-1:0];
        w_rpo_wa = i_req.node[NW-1:0]; w_dom_wa = r_bnode; w_dom_wd = r_pick;
        w_edge_wa = r_el[EW-1:0];
        unique case (i_cmd.op)
            OP_LOAD: begin
                if (w_first && w_node_bad) begin
                    n_ovf = 1'b1;
                end
                if (w_edge_try && w_edge_bad) begin
                    n_ovf = 1'b1;
                end
                if (w_first && !w_node_bad) begin
                    w_ord_we = 1'b1;
                    w_rpo_we = 1'b1;
                    n_rpo_vld[i_req.node[NW-1:0]] = 1'b1;
                    n_pc = r_pc + (NW+1)'(1);
                end
                if (w_kept) begin
                    w_cnt_we = 1'b1;
                    n_cur = w_cnt_new;
                end
                if (w_edge_ok) begin
                    w_edge_we = 1'b1;
                    n_el = r_el + (EW+1)'(1);
                end
                n_kept = w_kept;
                n_open = !(i_req.node_done || i_req.graph_done);
            end
            OP_I0: n_i = '0;
            OP_ROOT: begin
                w_dom_we = 1'b1;
                w_dom_wa = r_order_rd;
                w_dom_wd = r_order_rd;
                n_dom_vld[r_order_rd] = 1'b1;
                n_sweeps = '0;
                n_changed = 1'b1;
            end
            OP_SWEEP: begin
                n_changed = 1'b0;
                n_sweeps = r_sweeps + 8'd1;
                n_moved = '0;
                n_i = (NW+1)'(1);
            end
            OP_SETTLE: begin
                if (r_changed) begin
                    n_gaveup = r_gaveup | r_moved;
                end
                n_i = '0;
            end
            OP_NODE: begin
                n_bnode = r_order_rd;
                n_start = r_estart_rd;
                n_cnt = r_ecount_rd;
                n_k = '0;
                n_pick_ok = 1'b0;
            end
            OP_EADDR: n_e = w_esum[EW-1:0];
            OP_PRED: n_b = r_edge_rd;
            OP_SKIP: n_k = r_k + (EW+1)'(1);
            OP_TAKE: begin
                n_pick = r_b;
                n_pick_ok = 1'b1;
                n_a = r_b;
                n_k = r_k + (EW+1)'(1);
            end
            OP_MSTART: n_steps = '0;
            OP_MEET_OK: begin
                n_pick = r_a;
                n_k = r_k + (EW+1)'(1);
            end
            OP_FAIL: begin
                n_gaveup[r_bnode] = 1'b1;
                n_a = r_pick;
                n_k = r_k + (EW+1)'(1);
            end
            OP_STEP: n_steps = r_steps + 8'd1;
            OP_MOVE_A: n_a = r_dom_a;
            OP_MOVE_B: n_b = r_dom_b;
            OP_FIN: n_b = r_bnode;
            OP_UPDATE: begin
                if (w_upd) begin
                    w_dom_we = 1'b1;
                    n_dom_vld[r_bnode] = 1'b1;
                    n_moved[r_bnode] = 1'b1;
                    n_changed = 1'b1;
                end
                n_i = r_i + (NW+1)'(1);
            end
            OP_EPICK: n_b = r_order_rd;
            OP_EOUT: begin
                n_out.out_node = SLOT_W'(r_b);
                n_out.dominator = r_dom_b_ok ? SLOT_W'(r_dom_b) : '0;
                n_out.has_dominator = r_dom_b_ok;
                n_out.gave_up = r_gaveup[r_b];
                n_out.overflow = r_ovf;
                n_out.last = ((r_i + (NW+1)'(1)) == r_pc);
                n_out_valid = 1'b1;
                n_i = r_i + (NW+1)'(1);
            end
            OP_EEMPTY: begin
                n_out = '0;
                n_out.overflow = r_ovf;
                n_out.last = 1'b1;
                n_out_valid = 1'b1;
            end
            OP_CLEAR: begin
                n_pc = '0; n_el = '0; n_ovf = 1'b0; n_open = 1'b0; n_kept = 1'b0;
                n_rpo_vld = '0; n_dom_vld = '0; n_gaveup = '0; n_moved = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns <= NODE_SPACE_RST;
            r_pc <= '0; r_el <= '0; r_ovf <= 1'b0; r_open <= 1'b0; r_kept <= 1'b0;
            r_rpo_vld <= '0; r_dom_vld <= '0; r_gaveup <= '0; r_moved <= '0;
            r_changed <= 1'b0; r_pick_ok <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ns <= i_cfg_data;
            end
            r_pc <= n_pc; r_el <= n_el; r_ovf <= n_ovf; r_open <= n_open; r_kept <= n_kept;
            r_rpo_vld <= n_rpo_vld; r_dom_vld <= n_dom_vld;
            r_gaveup <= n_gaveup; r_moved <= n_moved;
            r_changed <= n_changed; r_pick_ok <= n_pick_ok; r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur; r_i <= n_i; r_e <= n_e; r_k <= n_k; r_start <= n_start;
        r_cnt <= n_cnt; r_bnode <= n_bnode; r_pick <= n_pick; r_a <= n_a; r_b <= n_b;
        r_steps <= n_steps; r_sweeps <= n_sweeps; r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_ord_we) begin
            r_order_mem[w_ord_wa] <= i_req.node[NW-1:0];
            r_estart_mem[w_ord_wa] <= r_el;
        end
        if (w_cnt_we) begin
            r_ecount_mem[w_cnt_wa] <= w_cnt_new;
        end
        if (w_rpo_we) begin
            r_rpo_mem[w_rpo_wa] <= r_pc[NW-1:0];
        end
        if (w_dom_we) begin
            r_dom_mem[w_dom_wa] <= w_dom_wd;
        end
        if (w_edge_we) begin
            r_edge_mem[w_edge_wa] <= i_req.pred[NW-1:0];
        end
        r_rpo_a <= r_rpo_mem[n_a];
        r_rpo_b <= r_rpo_mem[n_b];
        r_dom_a <= r_dom_mem[n_a];
        r_dom_b <= r_dom_mem[n_b];
        r_order_rd <= r_order_mem[n_i[NW-1:0]];
        r_estart_rd <= r_estart_mem[n_i[NW-1:0]];
        r_ecount_rd <= r_ecount_mem[n_i[NW-1:0]];
        r_edge_rd <= r_edge_mem[n_e];
    end

    always_ff @(posedge i_clk) begin
        r_rpo_a_ok <= n_rpo_vld[n_a] && r_rpo_vld[n_a];
        r_rpo_b_ok <= n_rpo_vld[n_b] && r_rpo_vld[n_b];
        r_dom_a_ok <= n_dom_vld[n_a] && r_dom_vld[n_a];
        r_dom_b_ok <= n_dom_vld[n_b] && r_dom_vld[n_b];
    end

    assign o_stat.pc_zero    = (r_pc == '0);
    assign o_stat.i_done     = (r_i >= r_pc);
    assign o_stat.k_done     = (r_k == r_cnt);
    assign o_stat.rpo_a_ok   = r_rpo_a_ok;
    assign o_stat.rpo_b_ok   = r_rpo_b_ok;
    assign o_stat.dom_a_ok   = r_dom_a_ok;
    assign o_stat.dom_b_ok   = r_dom_b_ok;
    assign o_stat.pick_ok    = r_pick_ok;
    assign o_stat.a_eq_b     = (r_a == r_b);
    assign o_stat.a_gt_b     = (r_rpo_a > r_rpo_b);
    assign o_stat.b_gt_a     = (r_rpo_b > r_rpo_a);
    assign o_stat.steps_over = (r_steps >= w_cap);
    assign o_stat.sweep_more = r_changed && (r_sweeps < w_cap);
    assign o_stat.emit_last  = ((r_i + (NW+1)'(1)) == r_pc);
    assign o_stat.out_free   = w_out_free;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    `DTF_ASSERT_IMP(a_pc_bound, i_clk, i_rst_n, 1'b1, r_pc <= (NW+1)'(MAX_NODES), "node count overrun")
    `DTF_ASSERT_IMP(a_el_bound, i_clk, i_rst_n, 1'b1, r_el <= (EW+1)'(MAX_EDGES), "edge count overrun")
    `DTF_ASSERT_IMP(a_k_bound, i_clk, i_rst_n, i_cmd.op == OP_EADDR, r_k < r_cnt, "edge walk overrun")

endmodule
`default_nettype wire

@@ design/dtf_ctrl.sv @@
`default_nettype none
`include "dominator_tree_fixpoint_top_macros.svh"
module dtf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_graph_done,
    input  wire dtf_pkg::t_stat i_stat,
    output logic                o_stall,
    output dtf_pkg::t_cmd       o_cmd
);
    import dtf_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_ROOT, S_SWEEP, S_NODE, S_EDGE, S_EWAIT, S_PCHK,
        S_MCHK, S_MA, S_MAW, S_MB, S_MBW, S_FIN, S_EMIT, S_EMIT2, S_EMPTY, S_CLEAR
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_stall  = (r_state != S_LOAD);
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    o_cmd.op = OP_LOAD;
                    if (i_graph_done) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.op = OP_I0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (i_stat.pc_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd.op = OP_ROOT;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (i_stat.sweep_more) begin
                    o_cmd.op = OP_SWEEP;
                    n_state = S_NODE;
                end else begin
                    o_cmd.op = OP_SETTLE;
                    n_state = S_EMIT;
                end
            end
            S_NODE: begin
                if (i_stat.i_done) begin
                    n_state = S_SWEEP;
                end else begin
                    o_cmd.op = OP_NODE;
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (i_stat.k_done) begin
                    o_cmd.op = OP_FIN;
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_EADDR;
                    n_state = S_EWAIT;
                end
            end
            S_EWAIT: begin
                o_cmd.op = OP_PRED;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                priority if (!i_stat.rpo_b_ok || !i_stat.dom_b_ok) begin
                    o_cmd.op = OP_SKIP;
                    n_state = S_EDGE;
                end else if (!i_stat.pick_ok) begin
                    o_cmd.op = OP_TAKE;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.op = OP_MSTART;
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                priority if (i_stat.a_eq_b) begin
                    o_cmd.op = OP_MEET_OK;
                    n_state = S_EDGE;
                end else if (i_stat.steps_over || !i_stat.rpo_a_ok || !i_stat.rpo_b_ok) begin
                    o_cmd.op = OP_FAIL;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state = S_MA;
                end
            end
            S_MA: begin
                priority if (!i_stat.a_gt_b) begin
                    n_state = S_MB;
                end else if (!i_stat.dom_a_ok) begin
                    o_cmd.op = OP_FAIL;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.op = OP_MOVE_A;
                    n_state = S_MAW;
                end
            end
            S_MAW: begin
                if (!i_stat.rpo_a_ok || i_stat.steps_over) begin
                    o_cmd.op = OP_FAIL;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state = S_MA;
                end
            end
            S_MB: begin
                priority if (!i_stat.b_gt_a) begin
                    n_state = S_MCHK;
                end else if (!i_stat.dom_b_ok) begin
                    o_cmd.op = OP_FAIL;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.op = OP_MOVE_B;
                    n_state = S_MBW;
                end
            end
            S_MBW: begin
                if (!i_stat.rpo_b_ok || i_stat.steps_over) begin
                    o_cmd.op = OP_FAIL;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.op = OP_STEP;
                    n_state = S_MB;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_UPDATE;
                n_state = S_NODE;
            end
            S_EMIT: begin
                o_cmd.op = OP_EPICK;
                n_state = S_EMIT2;
            end
            S_EMIT2: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EOUT;
                    n_state = i_stat.emit_last ? S_CLEAR : S_EMIT;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EEMPTY;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `DTF_ASSERT_IMP(a_eout_free, i_clk, i_rst_n, o_cmd.op == OP_EOUT || o_cmd.op == OP_EEMPTY, i_stat.out_free, "result overwrites pending result")
    `DTF_ASSERT_NXT(a_solve_start, i_clk, i_rst_n, w_accept && i_graph_done, r_state == S_INIT, "solve did not start")
    `DTF_ASSERT_IMP(a_meet_ready, i_clk, i_rst_n, o_cmd.op == OP_MSTART, i_stat.pick_ok, "meet without pick")

endmodule
`default_nettype wire

@@ design/dominator_tree_fixpoint_top.sv @@
`default_nettype none
// Dominator tree engine. A graph is loaded one request per cycle, node by node in reverse
// postorder with each node's predecessor list; the first node is the root. The request that
// carries graph_done starts the solve: each sweep walks the stored nodes after the root with
// one controller and one read per store port per cycle, stepping through each node, each of
// its predecessors and each intersection step; sweeps repeat until nothing changes, at most
// 2*node_space+4 of them. Results leave node by node, held while the output stalls; a clear
// readies the block for the next graph. Input stall stays high from graph_done until then.
module dominator_tree_fixpoint_top #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire dtf_pkg::t_in              i_req,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output dtf_pkg::t_out                  o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [dtf_pkg::CFG_W-1:0] i_cfg_data
);
    import dtf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    dtf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_graph_done (i_req.graph_done),
        .i_stat       (w_stat),
        .o_stall      (o_stall),
        .o_cmd        (w_cmd)
    );

    dtf_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_cmd      (w_cmd),
        .i_stall    (i_stall),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp)
    );

endmodule
`default_nettype wire
